FILE: sv/sequential_list_engine_macros.svh
// assertion macros for the sequential list engine checker
// no dependencies; included by the checker file only
`ifndef SEQUENTIAL_LIST_ENGINE_MACROS_SVH
`define SEQUENTIAL_LIST_ENGINE_MACROS_SVH

// same-cycle implication, disabled in reset
`define SLE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sle check failed");

// next-cycle implication, disabled in reset
`define SLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sle check failed");

`endif

FILE: sv/sle_pkg.sv
// shared types and codes for the sequential list engine
// no dependencies; used by the interfaces, the core and the top level
`default_nettype none

package sle_pkg;

   localparam int FUNC_W = 3;
   localparam int POS_W  = 9;
   localparam int DIN_W  = 32;
   localparam int STAT_W = 3;
   localparam int DOUT_W = 32;
   localparam int FPOS_W = 8;
   localparam int LEN_W  = 9;

   localparam logic [FUNC_W-1:0] OP_APPEND = 3'd0;
   localparam logic [FUNC_W-1:0] OP_INSERT = 3'd1;
   localparam logic [FUNC_W-1:0] OP_REMOVE = 3'd2;
   localparam logic [FUNC_W-1:0] OP_SET    = 3'd3;
   localparam logic [FUNC_W-1:0] OP_GET    = 3'd4;
   localparam logic [FUNC_W-1:0] OP_FIND   = 3'd5;
   localparam logic [FUNC_W-1:0] OP_CLEAR  = 3'd6;

   localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd2;
   localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
   localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [POS_W-1:0]  position;
      logic [DIN_W-1:0]  data_in;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [DOUT_W-1:0] data_out;
      logic [FPOS_W-1:0] found_position;
      logic [LEN_W-1:0]  length;
      logic              empty_res;
      logic              full_res;
   } rsp_type;

endpackage

`default_nettype wire

FILE: sv/sle_if.sv
// request and result channel interfaces with valid/ready handshake
// depends on sle_pkg for field widths
`default_nettype none

interface sle_req_if import sle_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [POS_W-1:0]  position;
   logic [DIN_W-1:0]  data_in;

   modport source (output valid, output func, output position, output data_in, input ready);
   modport sink (input valid, input func, input position, input data_in, output ready);
endinterface

interface sle_rsp_if import sle_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [DOUT_W-1:0] data_out;
   logic [FPOS_W-1:0] found_position;
   logic [LEN_W-1:0]  length;
   logic              empty_res;
   logic              full_res;

   modport source (output valid, output status, output data_out, output found_position,
                   output length, output empty_res, output full_res, input ready);
   modport sink (input valid, input status, input data_out, input found_position,
                 input length, input empty_res, input full_res, output ready);
endinterface

`default_nettype wire

FILE: sv/sle_core.sv
// list store and sequencer: entry memory, length count and the shift/scan walks
// depends on sle_pkg; instantiated by sequential_list_engine
`default_nettype none

module sle_core import sle_pkg::*; #(
   parameter int CAPACITY   = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_beat,
   output logic    res_valid,
   input  logic    res_ready,
   output rsp_type res_beat
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_UP   = 6'b000010,
      S_DOWN = 6'b000100,
      S_SCAN = 6'b001000,
      S_READ = 6'b010000,
      S_RESP = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         cur_ff, cur_in;
   logic [AW-1:0]         wa_ff, wa_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [STAT_W-1:0]     status_ff, status_in;
   logic [DATA_WIDTH-1:0] rdres_ff, rdres_in;
   logic [AW-1:0]         fpos_ff, fpos_in;

   logic [DATA_WIDTH-1:0] mem [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_q;
   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_waddr, mem_raddr;
   logic [DATA_WIDTH-1:0] mem_wdata;

   logic [PW-1:0]         req_pos_ext, count_ext;
   logic [DATA_WIDTH-1:0] req_val;
   logic [CW-1:0]         cur_dec, cur_inc;
   logic                  is_full, is_empty, accept;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_q <= mem[mem_raddr];
      end
   end

   assign req_pos_ext = PW'(req_beat.position);
   assign count_ext   = PW'(count_ff);
   assign req_val     = DATA_WIDTH'(req_beat.data_in);
   assign cur_dec     = cur_ff - 1'b1;
   assign cur_inc     = cur_ff + 1'b1;
   assign is_full     = (count_ff == CW'(CAPACITY));
   assign is_empty    = (count_ff == '0);
   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign res_valid   = (state_ff == S_RESP);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cur_in    = cur_ff;
      wa_in     = wa_ff;
      pend_in   = pend_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      status_in = status_ff;
      rdres_in  = rdres_ff;
      fpos_in   = fpos_ff;
      mem_we    = 1'b0;
      mem_waddr = wa_ff;
      mem_wdata = rd_q;
      mem_re    = 1'b0;
      mem_raddr = cur_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pos_in    = AW'(req_beat.position);
               val_in    = req_val;
               status_in = ST_OK;
               rdres_in  = '0;
               fpos_in   = '0;
               pend_in   = 1'b0;
               state_in  = S_RESP;
               unique case (req_beat.func)
                  OP_APPEND: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = req_val;
                        count_in  = count_ff + 1'b1;
                     end
                  end
                  OP_INSERT: begin
                     if (is_full) begin
                        status_in = ST_FULL;
                     end else if (req_pos_ext > count_ext) begin
                        status_in = ST_BADPOS;
                     end else begin
                        cur_in   = count_ff;
                        state_in = S_UP;
                     end
                  end
                  OP_REMOVE: begin
                     if (is_empty) begin
                        status_in = ST_EMPTY;
                     end else if (req_pos_ext >= count_ext) begin
                        status_in = ST_BADPOS;
                     end else begin
                        cur_in   = req_pos_ext[CW-1:0];
                        state_in = S_DOWN;
                     end
                  end
                  OP_SET: begin
                     if (req_pos_ext >= count_ext) begin
                        status_in = ST_BADPOS;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(req_beat.position);
                        mem_wdata = req_val;
                     end
                  end
                  OP_GET: begin
                     if (req_pos_ext >= count_ext) begin
                        status_in = ST_BADPOS;
                     end else begin
                        mem_re    = 1'b1;
                        mem_raddr = AW'(req_beat.position);
                        state_in  = S_READ;
                     end
                  end
                  OP_FIND: begin
                     status_in = ST_NOTFOUND;
                     cur_in    = '0;
                     state_in  = S_SCAN;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_UP: begin
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if (cur_ff > CW'(pos_ff)) begin
               mem_re    = 1'b1;
               mem_raddr = cur_dec[AW-1:0];
               wa_in     = cur_ff[AW-1:0];
               cur_in    = cur_dec;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = pos_ff;
                  mem_wdata = val_ff;
                  count_in  = count_ff + 1'b1;
                  state_in  = S_RESP;
               end
            end
         end
         S_DOWN: begin
            if (pend_ff) begin
               mem_we = 1'b1;
            end
            if (cur_inc < count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = cur_inc[AW-1:0];
               wa_in     = cur_ff[AW-1:0];
               cur_in    = cur_inc;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  count_in = count_ff - 1'b1;
                  state_in = S_RESP;
               end
            end
         end
         S_SCAN: begin
            if (pend_ff && (rd_q == val_ff)) begin
               status_in = ST_OK;
               fpos_in   = wa_ff;
               pend_in   = 1'b0;
               state_in  = S_RESP;
            end else if (cur_ff < count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = cur_ff[AW-1:0];
               wa_in     = cur_ff[AW-1:0];
               cur_in    = cur_inc;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_RESP;
               end
            end
         end
         S_READ: begin
            rdres_in = rd_q;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      cur_ff    <= cur_in;
      wa_ff     <= wa_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      rdres_ff  <= rdres_in;
      fpos_ff   <= fpos_in;
   end

   assign res_beat.status         = status_ff;
   assign res_beat.data_out       = DOUT_W'(rdres_ff);
   assign res_beat.found_position = FPOS_W'(fpos_ff);
   assign res_beat.length         = LEN_W'(count_ff);
   assign res_beat.empty_res      = is_empty;
   assign res_beat.full_res       = is_full;

endmodule

`default_nettype wire

FILE: sv/sequential_list_engine.sv
// sequential list engine: ordered word list with append, insert, remove, set, get, find, clear
// depends on sle_pkg, sle_if and sle_core
//
// req_if carries one operation per beat (func, position, data_in); rsp_if returns one
// result beat per request (status, data_out, found_position, length, empty/full flags).
// entries sit in one memory with one write and one registered read port, so insert,
// remove and find walk the list one entry per cycle.
// append, set, clear, an unused selector and rejected requests go straight to the result;
// get passes through a registered memory read first. insert shifts the entries from the
// requested position to the end up by one, remove shifts the entries above it down by one,
// and find scans from position 0 and stops at the first match.
// one request is in work at a time: the next request beat is taken in the cycle after the
// result has moved into the output register, so a result may wait at rsp_if meanwhile.
// reset empties the list; entry contents are not cleared and need no sweep.
// a stalled receiver holds the result in the output register and, once a second
// result is ready behind it, holds off further requests.
`default_nettype none

module sequential_list_engine import sle_pkg::*; #(
   parameter int CAPACITY   = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic      clock,
   input  logic      reset,
   sle_req_if.sink   req_if,
   sle_rsp_if.source rsp_if
);

   req_type req_beat;
   rsp_type res_beat;
   rsp_type out_ff, out_in;
   logic    out_valid_ff, out_valid_in;
   logic    res_valid, res_ready, core_ready;

   assign req_beat = '{func: req_if.func, position: req_if.position, data_in: req_if.data_in};
   assign req_if.ready = core_ready;

   sle_core #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (core_ready),
      .req_beat  (req_beat),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_beat  (res_beat)
   );

   // output register parts the core from the receiver
   assign res_ready = !out_valid_ff || rsp_if.ready;

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (res_valid && res_ready) begin
         out_in       = res_beat;
         out_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_ff <= out_in;
   end

   assign rsp_if.valid          = out_valid_ff;
   assign rsp_if.status         = out_ff.status;
   assign rsp_if.data_out       = out_ff.data_out;
   assign rsp_if.found_position = out_ff.found_position;
   assign rsp_if.length         = out_ff.length;
   assign rsp_if.empty_res      = out_ff.empty_res;
   assign rsp_if.full_res       = out_ff.full_res;

endmodule

`default_nettype wire

FILE: sv/sle_checker.sv
// port-level checks on the sequential list engine, bound to the top level
// depends on sequential_list_engine_macros.svh and sequential_list_engine
`default_nettype none
`include "sequential_list_engine_macros.svh"

module sle_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_data_out,
   input logic [7:0]  rsp_found_position,
   input logic [8:0]  rsp_length,
   input logic        rsp_empty_res,
   input logic        rsp_full_res
);

   logic [1:0] outst_ff, outst_in;
   logic       req_beat, rsp_beat;

   assign req_beat = req_valid && req_ready;
   assign rsp_beat = rsp_valid && rsp_ready;

   // requests taken but not yet answered
   always_comb begin
      outst_in = outst_ff;
      if (req_beat && !rsp_beat) begin
         outst_in = outst_ff + 1'b1;
      end else if (rsp_beat && !req_beat) begin
         outst_in = outst_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outst_ff <= '0;
      end else begin
         outst_ff <= outst_in;
      end
   end

   `SLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready && !reset, rsp_valid)
   `SLE_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready && !reset, $stable(rsp_status) && $stable(rsp_data_out) && $stable(rsp_found_position) && $stable(rsp_length) && $stable(rsp_empty_res) && $stable(rsp_full_res))
   `SLE_ASSERT_IMPLY(a_flags_excl, clock, reset, rsp_valid, !(rsp_empty_res && rsp_full_res))
   `SLE_ASSERT_IMPLY(a_no_orphan, clock, reset, rsp_valid, outst_ff != 2'd0)
   `SLE_ASSERT_IMPLY(a_outst_bound, clock, reset, req_beat, outst_ff != 2'd2)

endmodule

bind sequential_list_engine sle_checker u_sle_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_status         (rsp_if.status),
   .rsp_data_out       (rsp_if.data_out),
   .rsp_found_position (rsp_if.found_position),
   .rsp_length         (rsp_if.length),
   .rsp_empty_res      (rsp_if.empty_res),
   .rsp_full_res       (rsp_if.full_res)
);

`default_nettype wire

FILE: dv/tb_sequential_list_engine.sv
// self-checking testbench for the sequential list engine: directed table then random phases
// depends on sle_pkg, sle_if and sequential_list_engine; results checked against a shadow list
`default_nettype none

module tb_sequential_list_engine;
   import sle_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY     = 256;
   localparam int RANDOM_ITEMS = 1525;
   localparam int DRAIN_CYCLES = 300;

   localparam logic [FUNC_W-1:0] OP_UNUSED = 3'd7;

   typedef enum {MODE_GROW, MODE_SHRINK, MODE_CHURN, MODE_NOISE} stim_mode;

   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type want;
   } script_row;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic sink_ready = 1'b0;

   sle_req_if req_if ();
   sle_rsp_if rsp_if ();

   assign rsp_if.ready = sink_ready;

   sequential_list_engine #(.CAPACITY(CAPACITY), .DATA_WIDTH(32)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #6 clock = ~clock;

   logic [DIN_W-1:0] shadow_words [CAPACITY];
   int               shadow_len = 0;
   rsp_type          pending_results [$];
   script_row        directed_rows [$];
   int               error_count = 0;
   bit               tx_quiet = 1'b0;
   bit               rx_quiet = 1'b0;
   int               stall_left = 0;

   function automatic rsp_type apply_list_op(input req_type r);
      rsp_type res;
      int      pos;
      int      i;
      res = '0;
      pos = r.position;
      res.status = ST_OK;
      case (r.func)
         OP_APPEND: begin
            if (shadow_len >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               shadow_words[shadow_len] = r.data_in;
               shadow_len++;
            end
         end
         OP_INSERT: begin
            if (shadow_len >= CAPACITY) begin
               res.status = ST_FULL;
            end else if (pos > shadow_len) begin
               res.status = ST_BADPOS;
            end else begin
               for (i = shadow_len; i > pos; i--) shadow_words[i] = shadow_words[i-1];
               shadow_words[pos] = r.data_in;
               shadow_len++;
            end
         end
         OP_REMOVE: begin
            if (shadow_len == 0) begin
               res.status = ST_EMPTY;
            end else if (pos >= shadow_len) begin
               res.status = ST_BADPOS;
            end else begin
               for (i = pos; i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
               shadow_len--;
            end
         end
         OP_SET: begin
            if (pos >= shadow_len) res.status = ST_BADPOS;
            else shadow_words[pos] = r.data_in;
         end
         OP_GET: begin
            if (pos >= shadow_len) res.status = ST_BADPOS;
            else res.data_out = shadow_words[pos];
         end
         OP_FIND: begin
            res.status = ST_NOTFOUND;
            for (i = 0; i < shadow_len; i++) begin
               if (shadow_words[i] == r.data_in) begin
                  res.status = ST_OK;
                  res.found_position = i[FPOS_W-1:0];
                  break;
               end
            end
         end
         OP_CLEAR: shadow_len = 0;
         default: ;
      endcase
      res.length    = shadow_len[LEN_W-1:0];
      res.empty_res = (shadow_len == 0);
      res.full_res  = (shadow_len == CAPACITY);
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(12, 4);
      return $urandom_range(40, 20);
   endfunction

   function automatic req_type build_request(input stim_mode mode);
      req_type r;
      int      roll;
      int      hi;
      r = '0;
      roll = $urandom_range(99);
      if (mode == MODE_NOISE) begin
         r.func     = FUNC_W'($urandom_range(7));
         r.position = POS_W'($urandom_range(511));
         r.data_in  = $urandom;
         return r;
      end
      case (mode)
         MODE_GROW:
            r.func = (roll < 50) ? OP_APPEND : (roll < 85) ? OP_INSERT :
                     (roll < 90) ? OP_GET : (roll < 95) ? OP_SET : OP_FIND;
         MODE_SHRINK:
            r.func = (roll < 60) ? OP_REMOVE : (roll < 70) ? OP_GET :
                     (roll < 80) ? OP_FIND : (roll < 90) ? OP_SET :
                     (roll < 95) ? OP_APPEND : OP_INSERT;
         default:
            r.func = (roll < 18) ? OP_APPEND : (roll < 36) ? OP_INSERT :
                     (roll < 54) ? OP_REMOVE : (roll < 68) ? OP_SET :
                     (roll < 82) ? OP_GET : (roll < 96) ? OP_FIND :
                     (roll < 98) ? OP_CLEAR : OP_UNUSED;
      endcase
      roll = $urandom_range(99);
      if (roll < 80) begin
         hi = (r.func == OP_INSERT) ? shadow_len : shadow_len - 1;
         r.position = (hi > 0) ? POS_W'($urandom_range(hi)) : '0;
      end else if (roll < 90) begin
         r.position = POS_W'(shadow_len + $urandom_range(2));
      end else begin
         r.position = POS_W'($urandom_range(511));
      end
      roll = $urandom_range(99);
      if (r.func == OP_FIND && shadow_len > 0 && roll < 60)
         r.data_in = shadow_words[$urandom_range(shadow_len - 1)];
      else if (roll < 75)
         r.data_in = $urandom_range(7);
      else
         r.data_in = $urandom;
      return r;
   endfunction

   function automatic script_row plain_row(input logic [FUNC_W-1:0] func, input int pos,
                                           input logic [DIN_W-1:0] din);
      script_row row;
      row.beat.func     = func;
      row.beat.position = pos[POS_W-1:0];
      row.beat.data_in  = din;
      row.typed         = 1'b0;
      row.want          = '0;
      return row;
   endfunction

   function automatic script_row typed_row(input logic [FUNC_W-1:0] func, input int pos,
                                           input logic [DIN_W-1:0] din,
                                           input logic [STAT_W-1:0] status,
                                           input logic [DOUT_W-1:0] dout, input int len);
      script_row row;
      row = plain_row(func, pos, din);
      row.typed               = 1'b1;
      row.want.status         = status;
      row.want.data_out       = dout;
      row.want.found_position = '0;
      row.want.length         = len[LEN_W-1:0];
      row.want.empty_res      = (len == 0);
      row.want.full_res       = (len == CAPACITY);
      return row;
   endfunction

   task automatic drive_request(input req_type r);
      int gap;
      gap = tx_quiet ? 0 : pick_gap();
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.func     <= r.func;
      req_if.position <= r.position;
      req_if.data_in  <= r.data_in;
      do @(posedge clock); while (!req_if.ready);
   endtask

   function automatic void check_field(input string name, input longint unsigned want,
                                       input longint unsigned got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   task automatic check_result();
      rsp_type want;
      if (pending_results.size() == 0) begin
         error_count++;
         $display("%0t: result beat with nothing expected, actual status %0d length %0d",
                  $time, rsp_if.status, rsp_if.length);
         return;
      end
      want = pending_results.pop_front();
      check_field("status", want.status, rsp_if.status);
      check_field("data_out", want.data_out, rsp_if.data_out);
      check_field("found_position", want.found_position, rsp_if.found_position);
      check_field("length", want.length, rsp_if.length);
      check_field("empty_res", want.empty_res, rsp_if.empty_res);
      check_field("full_res", want.full_res, rsp_if.full_res);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) check_result();
      if (stall_left > 0) begin
         stall_left--;
         sink_ready <= 1'b0;
      end else if (!rx_quiet && $urandom_range(99) < 20) begin
         stall_left = pick_gap();
         sink_ready <= 1'b0;
      end else begin
         sink_ready <= 1'b1;
      end
   end

   initial begin
      #40_000_000;
      $display("sequential_list_engine verification failed");
      $finish;
   end

   initial begin
      req_type  beat;
      rsp_type  want;
      stim_mode mode;
      int       sent;
      int       phase_left;
      int       roll;

      req_if.valid    = 1'b0;
      req_if.func     = OP_APPEND;
      req_if.position = '0;
      req_if.data_in  = '0;

      // empty list corner cases first
      directed_rows.push_back(typed_row(OP_GET, 0, 32'h0, ST_BADPOS, 32'h0, 0));
      directed_rows.push_back(typed_row(OP_REMOVE, 0, 32'h0, ST_EMPTY, 32'h0, 0));
      directed_rows.push_back(typed_row(OP_FIND, 0, 32'h0, ST_NOTFOUND, 32'h0, 0));
      directed_rows.push_back(typed_row(OP_SET, 0, 32'h1, ST_BADPOS, 32'h0, 0));
      directed_rows.push_back(typed_row(OP_INSERT, 1, 32'h1, ST_BADPOS, 32'h0, 0));
      directed_rows.push_back(typed_row(OP_UNUSED, 511, 32'hFFFF_FFFF, ST_OK, 32'h0, 0));
      directed_rows.push_back(typed_row(OP_INSERT, 0, 32'hFFFF_FFFF, ST_OK, 32'h0, 1));
      directed_rows.push_back(typed_row(OP_APPEND, 511, 32'h0, ST_OK, 32'h0, 2));
      directed_rows.push_back(typed_row(OP_APPEND, 0, 32'hA5A5_A5A5, ST_OK, 32'h0, 3));
      directed_rows.push_back(typed_row(OP_INSERT, 3, 32'h5A5A_5A5A, ST_OK, 32'h0, 4));
      directed_rows.push_back(plain_row(OP_INSERT, 1, 32'h1234_5678));
      directed_rows.push_back(typed_row(OP_GET, 0, 32'h0, ST_OK, 32'hFFFF_FFFF, 5));
      directed_rows.push_back(typed_row(OP_GET, 4, 32'h0, ST_OK, 32'h5A5A_5A5A, 5));
      directed_rows.push_back(typed_row(OP_GET, 5, 32'h0, ST_BADPOS, 32'h0, 5));
      directed_rows.push_back(typed_row(OP_GET, 256, 32'h0, ST_BADPOS, 32'h0, 5));
      directed_rows.push_back(typed_row(OP_SET, 511, 32'h0, ST_BADPOS, 32'h0, 5));
      directed_rows.push_back(plain_row(OP_FIND, 0, 32'h5A5A_5A5A));
      directed_rows.push_back(typed_row(OP_FIND, 0, 32'hDEAD_BEEF, ST_NOTFOUND, 32'h0, 5));
      directed_rows.push_back(typed_row(OP_SET, 2, 32'hDEAD_BEEF, ST_OK, 32'h0, 5));
      directed_rows.push_back(plain_row(OP_FIND, 0, 32'hDEAD_BEEF));
      directed_rows.push_back(plain_row(OP_REMOVE, 0, 32'h0));
      directed_rows.push_back(typed_row(OP_REMOVE, 4, 32'h0, ST_BADPOS, 32'h0, 4));
      directed_rows.push_back(plain_row(OP_REMOVE, 3, 32'h0));
      directed_rows.push_back(plain_row(OP_INSERT, 0, 32'h1));
      directed_rows.push_back(typed_row(OP_CLEAR, 511, 32'hFFFF_FFFF, ST_OK, 32'h0, 0));
      directed_rows.push_back(plain_row(OP_APPEND, 0, 32'h7));
      directed_rows.push_back(plain_row(OP_GET, 0, 32'h0));

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) begin
         want = apply_list_op(directed_rows[k].beat);
         pending_results.push_back(directed_rows[k].typed ? directed_rows[k].want : want);
         drive_request(directed_rows[k].beat);
      end

      // first random phase fills the list so the full cases are always hit
      sent = 0;
      mode = MODE_GROW;
      while (sent < RANDOM_ITEMS) begin
         tx_quiet = ($urandom_range(3) == 0);
         rx_quiet = ($urandom_range(3) == 0);
         if (mode == MODE_GROW || mode == MODE_SHRINK) phase_left = $urandom_range(12, 4);
         else phase_left = $urandom_range(120, 30);
         while (sent < RANDOM_ITEMS && phase_left > 0) begin
            beat = build_request(mode);
            pending_results.push_back(apply_list_op(beat));
            drive_request(beat);
            sent++;
            if (!((mode == MODE_GROW && shadow_len != CAPACITY) ||
                  (mode == MODE_SHRINK && shadow_len != 0)))
               phase_left--;
         end
         roll = $urandom_range(99);
         mode = (roll < 18) ? MODE_GROW : (roll < 33) ? MODE_SHRINK :
                (roll < 85) ? MODE_CHURN : MODE_NOISE;
      end

      req_if.valid <= 1'b0;
      rx_quiet = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("sequential_list_engine verification clean");
      end else begin
         $display("sequential_list_engine verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
